FILE: rtl/soiir_pkg.sv
package soiir_pkg;

    localparam int COEF_WIDTH      = 32;
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_COEF_B0 = 2'd0,
        REG_COEF_B2 = 2'd1,
        REG_COEF_A1 = 2'd2,
        REG_COEF_A2 = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [COEF_WIDTH-1:0] b0;
        logic [COEF_WIDTH-1:0] b2;
        logic [COEF_WIDTH-1:0] a1;
        logic [COEF_WIDTH-1:0] a2;
    } t_coefs;

endpackage

FILE: rtl/soiir_cfg.sv
module soiir_cfg (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [soiir_pkg::CFG_INDEX_WIDTH-1:0]  i_index,
    input  logic [soiir_pkg::COEF_WIDTH-1:0]       i_data,
    output soiir_pkg::t_coefs                      o_coefs
);
    import soiir_pkg::*;

    t_coefs r_coefs;

    assign o_ready = 1'b1;
    assign o_coefs = r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_valid && o_ready) begin
            unique case (t_cfg_index'(i_index))
                REG_COEF_B0: begin
                    r_coefs.b0 <= i_data;
                end
                REG_COEF_B2: begin
                    r_coefs.b2 <= i_data;
                end
                REG_COEF_A1: begin
                    r_coefs.a1 <= i_data;
                end
                REG_COEF_A2: begin
                    r_coefs.a2 <= i_data;
                end
                default: begin
                    r_coefs <= r_coefs;
                end
            endcase
        end
    end

endmodule

FILE: rtl/soiir_core.sv
module soiir_core #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  soiir_pkg::t_coefs              i_coefs,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out
);
    import soiir_pkg::*;

    localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_WIDTH  = PROD_WIDTH + 3;

    localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF =
        {{(ACC_WIDTH-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_WIDTH-1:0] SAT_MAX =
        {{(ACC_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] SAT_MIN =
        {{(ACC_WIDTH-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    logic                           r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_x1;
    logic signed [SAMPLE_WIDTH-1:0] r_x2;
    logic signed [SAMPLE_WIDTH-1:0] r_y1;
    logic signed [SAMPLE_WIDTH-1:0] r_y2;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_y;

    logic                           advance;
    logic                           load_in;
    logic                           produce;
    logic signed [COEF_WIDTH-1:0]   coef_b0;
    logic signed [COEF_WIDTH-1:0]   coef_b2;
    logic signed [COEF_WIDTH-1:0]   coef_a1;
    logic signed [COEF_WIDTH-1:0]   coef_a2;
    logic signed [PROD_WIDTH-1:0]   prod_b0;
    logic signed [PROD_WIDTH-1:0]   prod_b2;
    logic signed [PROD_WIDTH-1:0]   prod_a1;
    logic signed [PROD_WIDTH-1:0]   prod_a2;
    logic signed [ACC_WIDTH-1:0]    acc;
    logic signed [ACC_WIDTH-1:0]    shifted;
    logic signed [SAMPLE_WIDTH-1:0] n_y;

    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign load_in     = i_in_valid && !o_in_stall;
    assign produce     = r_in_valid && advance;
    assign o_out_valid = r_out_valid;
    assign o_sample_out = r_y;

    assign coef_b0 = i_coefs.b0;
    assign coef_b2 = i_coefs.b2;
    assign coef_a1 = i_coefs.a1;
    assign coef_a2 = i_coefs.a2;

    assign prod_b0 = coef_b0 * r_x;
    assign prod_b2 = coef_b2 * r_x2;
    assign prod_a1 = coef_a1 * r_y1;
    assign prod_a2 = coef_a2 * r_y2;

    assign acc = ACC_WIDTH'(prod_b0) + ACC_WIDTH'(prod_b2)
               - ACC_WIDTH'(prod_a1) - ACC_WIDTH'(prod_a2) + ROUND_HALF;
    assign shifted = acc >>> COEF_FRAC_BITS;

    always_comb begin
        priority if (shifted > SAT_MAX) begin
            n_y = SAT_MAX[SAMPLE_WIDTH-1:0];
        end else if (shifted < SAT_MIN) begin
            n_y = SAT_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            n_y = shifted[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (produce) begin
                r_x2 <= r_x1;
                r_x1 <= r_x;
                r_y2 <= r_y1;
                r_y1 <= n_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_x <= i_sample_in;
        end
        if (produce) begin
            r_y <= n_y;
        end
    end

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce |=> (r_out_valid && r_y == r_y1))
        else $error("result register and output history disagree");

    a_history_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce |=> (r_y2 == $past(r_y1) && r_x2 == $past(r_x1) && r_x1 == $past(r_x)))
        else $error("delay line did not shift on a produced result");

    a_history_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !produce |=> ($stable(r_y1) && $stable(r_y2) && $stable(r_x1) && $stable(r_x2)))
        else $error("delay line changed without a transaction");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_x1 == '0 && r_x2 == '0 && r_y1 == '0 && r_y2 == '0 && !r_out_valid))
        else $error("reset did not clear the filter state");
`endif

endmodule

FILE: rtl/second_order_iir_filter.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_sample_in
// output    out        o_out_valid / i_out_stall o_sample_out
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An accepted sample is held in the input register and its result is then registered in the
// result register, from which it is taken; one sample is accepted every cycle while the output
// is not stalled; the four coefficient multiplies, the adder tree, rounding and saturation sit
// between the input register and the result register, closing the output feedback.
// Reset clears the coefficients, the delay line and both valid flags.
// A stalled result holds the result register; the input is stalled while the input register
// holds a sample and the result is stalled, so the stall reaches the input at once when that
// register is full and only after a sample has been loaded into it when it is empty.
module second_order_iir_filter #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]        o_sample_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [soiir_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [soiir_pkg::COEF_WIDTH-1:0]      i_cfg_data
);
    import soiir_pkg::*;

    t_coefs coefs;

    soiir_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_coefs (coefs)
    );

    soiir_core #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coefs      (coefs),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out)
    );

endmodule

FILE: tb/second_order_iir_filter_checker.sv
`timescale 1ns / 100ps

module second_order_iir_filter_checker #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample_in,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample_out,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [soiir_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [soiir_pkg::COEF_WIDTH-1:0]      i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_outstanding,
    output int                                    o_checked
);

    import soiir_pkg::*;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [COEF_WIDTH-1:0]   t_coef;

    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_WIDTH - 1));

    t_coef   gain_b0, gain_b2, gain_a1, gain_a2;
    t_sample x_prev1, x_prev2, y_prev1, y_prev2;
    t_sample filtered_q[$];
    t_sample predicted, wanted;
    int      fail_total;
    int      checked_total;

    function automatic t_sample filter_output(input t_sample x);
        longint acc;
        acc = longint'(gain_b0) * longint'(x)
            + longint'(gain_b2) * longint'(x_prev2)
            - longint'(gain_a1) * longint'(y_prev1)
            - longint'(gain_a2) * longint'(y_prev2)
            + (longint'(1) <<< (COEF_FRAC_BITS - 1));
        acc = acc >>> COEF_FRAC_BITS;
        if (acc > SAMPLE_MAX) begin
            acc = SAMPLE_MAX;
        end else if (acc < SAMPLE_MIN) begin
            acc = SAMPLE_MIN;
        end
        return t_sample'(acc);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gain_b0 = '0;
            gain_b2 = '0;
            gain_a1 = '0;
            gain_a2 = '0;
            x_prev1 = '0;
            x_prev2 = '0;
            y_prev1 = '0;
            y_prev2 = '0;
            filtered_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    REG_COEF_B0: gain_b0 = i_cfg_data;
                    REG_COEF_B2: gain_b2 = i_cfg_data;
                    REG_COEF_A1: gain_a1 = i_cfg_data;
                    REG_COEF_A2: gain_a2 = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predicted = filter_output(i_sample_in);
                filtered_q.push_back(predicted);
                x_prev2 = x_prev1;
                x_prev1 = i_sample_in;
                y_prev2 = y_prev1;
                y_prev1 = predicted;
            end
            if (i_out_valid && !i_out_stall) begin
                if (filtered_q.size() == 0) begin
                    $error("sample_out: result with no sample pending, actual %0d",
                           i_sample_out);
                    fail_total++;
                end else begin
                    wanted = filtered_q.pop_front();
                    if (i_sample_out !== wanted) begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               wanted, i_sample_out);
                        fail_total++;
                    end
                    checked_total++;
                end
            end
        end
        o_fail_count  <= fail_total;
        o_outstanding <= filtered_q.size();
        o_checked     <= checked_total;
    end

endmodule

FILE: tb/second_order_iir_filter_tb.sv
`timescale 1ns / 100ps

module second_order_iir_filter_tb;

    import soiir_pkg::*;

    localparam int SAMPLE_WIDTH   = 24;
    localparam int COEF_FRAC_BITS = 28;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SAMPLES  = 190;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    localparam t_sample S_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam t_sample S_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    localparam logic [COEF_WIDTH-1:0] C_ZERO  = 32'h0000_0000;
    localparam logic [COEF_WIDTH-1:0] C_UNITY = 32'h1000_0000;
    localparam logic [COEF_WIDTH-1:0] C_HALF  = 32'h0800_0000;
    localparam logic [COEF_WIDTH-1:0] C_MAX   = 32'h7FFF_FFFF;
    localparam logic [COEF_WIDTH-1:0] C_MIN   = 32'h8000_0000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    t_sample                    i_sample_in;
    logic                       o_out_valid;
    logic                       i_out_stall;
    t_sample                    o_sample_out;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [COEF_WIDTH-1:0]      i_cfg_data;

    int      fail_count;
    int      outstanding;
    int      checked;
    int      in_gap_pct;
    int      out_stall_pct;
    int      samples_sent;
    int      coef_sets;
    int      spread_b;
    int      spread_a1;
    int      spread_a2;
    t_sample sample_queue[$];
    t_sample last_sample;

    always #1 i_clk = ~i_clk;

    second_order_iir_filter #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    second_order_iir_filter_checker #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_sample_in   (i_sample_in),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_sample_out  (o_sample_out),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    task automatic load_coefs(input logic [COEF_WIDTH-1:0] b0, b2, a1, a2);
        logic [COEF_WIDTH-1:0] values [4];
        t_cfg_index            targets [4];
        values  = '{b0, b2, a1, a2};
        targets = '{REG_COEF_B0, REG_COEF_B2, REG_COEF_A1, REG_COEF_A2};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= targets[k];
            i_cfg_data  <= values[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        coef_sets++;
    endtask

    task automatic play_samples();
        t_sample next_sample;
        while (sample_queue.size() > 0) begin
            next_sample = sample_queue.pop_front();
            if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            i_in_valid  <= 1'b1;
            i_sample_in <= next_sample;
            do @(posedge i_clk); while (o_in_stall);
            samples_sent++;
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    function automatic t_sample random_sample();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? S_MAX : S_MIN;
            1, 2:    return t_sample'(int'($urandom_range(0, 512)) - 256);
            3, 4:    return last_sample;
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_WIDTH-1:0] random_coef(input int spread);
        if (spread == 0) begin
            return $urandom;
        end
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    initial begin
        out_stall_pct = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        in_gap_pct   = 0;
        samples_sent = 0;
        coef_sets    = 0;
        last_sample  = '0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_sample_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_COEF_B0;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_gap_pct    = 25;
        out_stall_pct = 25;
        sample_queue = '{S_MAX, S_MIN};
        play_samples();
        wait_idle();

        load_coefs(C_UNITY, C_ZERO, C_ZERO, C_ZERO);
        sample_queue = '{S_MAX, S_MIN, t_sample'(0), t_sample'(-1), t_sample'(1)};
        play_samples();
        wait_idle();

        // Halves round towards plus infinity.
        load_coefs(C_HALF, C_ZERO, C_ZERO, C_ZERO);
        sample_queue = '{t_sample'(1), t_sample'(-1), t_sample'(3), t_sample'(-3)};
        play_samples();
        wait_idle();

        load_coefs(C_MAX, C_MIN, C_MIN, C_MAX);
        sample_queue = '{S_MAX, S_MIN, S_MAX, S_MIN};
        play_samples();
        wait_idle();

        load_coefs(C_MIN, C_MAX, C_MAX, C_MIN);
        sample_queue = '{S_MAX, S_MIN, S_MAX, S_MIN};
        play_samples();
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0 || phase == RANDOM_PHASES - 1) begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end else begin
                in_gap_pct    = $urandom_range(5, 40);
                out_stall_pct = $urandom_range(5, 40);
            end
            case (phase % 3)
                0: begin
                    spread_b  = 0;
                    spread_a1 = 0;
                    spread_a2 = 0;
                end
                1: begin
                    spread_b  = 32'h2000_0000;
                    spread_a1 = 32'h2000_0000;
                    spread_a2 = 32'h2000_0000;
                end
                default: begin
                    spread_b  = 32'h1000_0000;
                    spread_a1 = 32'h2000_0000;
                    spread_a2 = 32'h0E00_0000;
                end
            endcase
            load_coefs(random_coef(spread_b), random_coef(spread_b),
                       random_coef(spread_a1), random_coef(spread_a2));
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                last_sample = random_sample();
                sample_queue.push_back(last_sample);
            end
            play_samples();
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        $display("Sent %0d samples through %0d coefficient settings; %0d results checked.",
                 samples_sent, coef_sets, checked);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
